[hw/rtl/mssd_pkg.sv]
// Shared types, codes and helper functions of the seven-segment display driver.
package mssd_pkg;

    localparam int DIGITS_DEFAULT = 4;
    localparam int VALUE_W        = 16;
    localparam int CODE_W         = 8;
    localparam int ENABLE_W       = 4;

    typedef enum logic [1:0] {
        KIND_TICK   = 2'd0,
        KIND_NUMBER = 2'd1,
        KIND_RAW    = 2'd2,
        KIND_TOGGLE = 2'd3
    } kind_t;

    localparam logic [1:0] MODE_ZERO_PAD    = 2'd0;
    localparam logic [1:0] MODE_BLANK       = 2'd1;
    localparam logic [1:0] MODE_SIGNIFICANT = 2'd2;

    localparam logic [CODE_W-1:0] DP_MASK = 8'h80;

    typedef struct packed {
        logic [VALUE_W-1:0] quot;
        logic [3:0]         digit;
    } div10_t;

    // x / 10 == (x * 0xCCCD) >> 19 holds for every 16-bit x
    function automatic div10_t div10(input logic [VALUE_W-1:0] v);
        logic [31:0]        prod;
        logic [VALUE_W-1:0] q;
        logic [VALUE_W-1:0] rem;
        div10_t             r;
        prod = {16'd0, v} * 32'd52429;
        q = {3'd0, prod[31:19]};
        rem = v - ((q << 3) + (q << 1));
        r.quot = q;
        r.digit = rem[3:0];
        return r;
    endfunction

    function automatic logic [CODE_W-1:0] seg7(input logic [3:0] d);
        logic [CODE_W-1:0] s;
        case (d)
            4'd0:    s = 8'h3F;
            4'd1:    s = 8'h06;
            4'd2:    s = 8'h5B;
            4'd3:    s = 8'h4F;
            4'd4:    s = 8'h66;
            4'd5:    s = 8'h6D;
            4'd6:    s = 8'h7D;
            4'd7:    s = 8'h07;
            4'd8:    s = 8'h7F;
            4'd9:    s = 8'h6F;
            default: s = 8'h00;
        endcase
        return s;
    endfunction

endpackage

[hw/rtl/mssd_ifs.sv]
// Valid/ready channel interfaces for items and scan results.
interface mssd_item_if;
    import mssd_pkg::*;
    logic                valid;
    logic                ready;
    kind_t               kind;
    logic [VALUE_W-1:0]  value;
    logic [1:0]          position;
    logic [CODE_W-1:0]   code;

    modport source (output valid, kind, value, position, code, input ready);
    modport sink   (input valid, kind, value, position, code, output ready);
endinterface

interface mssd_result_if;
    import mssd_pkg::*;
    logic                valid;
    logic                ready;
    logic [CODE_W-1:0]   segments;
    logic [ENABLE_W-1:0] digit_enable;

    modport source (output valid, segments, digit_enable, input ready);
    modport sink   (input valid, segments, digit_enable, output ready);
endinterface

[hw/rtl/mssd_front.sv]
// Front end: takes items, splits numbers into decimal digits, builds buffer update ops.
module mssd_front #(
    parameter int DIGITS = mssd_pkg::DIGITS_DEFAULT
) (
    input  logic                                clk,
    input  logic                                rst_n,
    mssd_item_if.sink                           item,
    input  logic [1:0]                          number_mode,
    output logic                                op_valid,
    input  logic                                op_ready,
    output mssd_pkg::kind_t                     op_kind,
    output logic [DIGITS-1:0]                   op_mask,
    output logic [DIGITS-1:0][mssd_pkg::CODE_W-1:0] op_codes
);
    import mssd_pkg::*;

    typedef struct packed {
        kind_t                   kind;
        logic [1:0]              position;
        logic [CODE_W-1:0]       code;
        logic [VALUE_W-1:0]      quot;
        logic [DIGITS-1:0][3:0]  digit;
    } stage_t;

    stage_t            stage_reg  [DIGITS];
    stage_t            stage_next [DIGITS];
    logic [DIGITS-1:0] valid_reg;
    logic [DIGITS-1:0] valid_next;
    logic [DIGITS:0]   adv;

    // stage s holds digits 0..s and the quotient left after them
    always_comb
    begin
        div10_t split;
        split = '0;
        adv[DIGITS] = op_ready;
        for (int s = DIGITS - 1; s >= 0; s--)
        begin
            adv[s] = !valid_reg[s] || adv[s+1];
        end
        valid_next = valid_reg;
        for (int s = 0; s < DIGITS; s++)
        begin
            stage_next[s] = stage_reg[s];
        end
        if (adv[0])
        begin
            split = div10(item.value);
            valid_next[0] = item.valid;
            stage_next[0].kind = item.kind;
            stage_next[0].position = item.position;
            stage_next[0].code = item.code;
            stage_next[0].digit = '0;
            stage_next[0].digit[0] = split.digit;
            stage_next[0].quot = split.quot;
        end
        for (int s = 1; s < DIGITS; s++)
        begin
            if (adv[s])
            begin
                split = div10(stage_reg[s-1].quot);
                valid_next[s] = valid_reg[s-1];
                stage_next[s] = stage_reg[s-1];
                stage_next[s].digit[s] = split.digit;
                stage_next[s].quot = split.quot;
            end
        end
    end

    assign item.ready = adv[0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int s = 0; s < DIGITS; s++)
        begin
            stage_reg[s] <= stage_next[s];
        end
    end

    // classify the oldest item into a per-position write mask and codes
    always_comb
    begin
        stage_t            last;
        logic              nz;
        logic [DIGITS-1:0] hi_nz;
        logic [3:0]        pos_r;
        logic [DIGITS-1:0] pos_hot;
        logic [CODE_W-1:0] seg;
        logic              wr;
        last = stage_reg[DIGITS-1];
        seg = '0;
        wr = 1'b0;
        nz = 1'b0;
        for (int i = DIGITS - 1; i >= 0; i--)
        begin
            nz = nz | (last.digit[i] != 4'd0);
            hi_nz[i] = nz;
        end
        pos_r = {2'b00, last.position};
        for (int k = 0; k < 4; k++)
        begin
            if (pos_r >= 4'(DIGITS))
            begin
                pos_r = pos_r - 4'(DIGITS);
            end
        end
        for (int j = 0; j < DIGITS; j++)
        begin
            pos_hot[j] = (pos_r == 4'(j));
        end
        op_kind = last.kind;
        op_mask = '0;
        op_codes = '0;
        case (last.kind)
            KIND_NUMBER:
            begin
                // digit i goes to position DIGITS-1-i
                for (int i = 0; i < DIGITS; i++)
                begin
                    seg = seg7(last.digit[i]);
                    case (number_mode)
                        MODE_ZERO_PAD:
                        begin
                            wr = 1'b1;
                        end
                        MODE_BLANK:
                        begin
                            wr = 1'b1;
                            if (i > 0 && !hi_nz[i])
                            begin
                                seg = '0;
                            end
                        end
                        default:
                        begin
                            wr = (i == 0) || hi_nz[i];
                        end
                    endcase
                    op_mask[DIGITS-1-i] = wr;
                    op_codes[DIGITS-1-i] = seg;
                end
            end
            KIND_RAW:
            begin
                op_mask = pos_hot;
                for (int j = 0; j < DIGITS; j++)
                begin
                    op_codes[j] = last.code;
                end
            end
            KIND_TOGGLE:
            begin
                op_mask = pos_hot;
            end
            default:
            begin
                op_mask = '0;
            end
        endcase
    end

    assign op_valid = valid_reg[DIGITS-1];

endmodule

[hw/rtl/mssd_fifo.sv]
// Two-entry queue between the front end and the display back end.
module mssd_fifo #(
    parameter int WIDTH = 8
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic [WIDTH-1:0] in_data,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [WIDTH-1:0] out_data
);
    logic [WIDTH-1:0] mem_reg [2];
    logic             wr_ptr_reg;
    logic             wr_ptr_next;
    logic             rd_ptr_reg;
    logic             rd_ptr_next;
    logic [1:0]       count_reg;
    logic [1:0]       count_next;
    logic             push;
    logic             pop;

    assign in_ready  = (count_reg != 2'd2);
    assign out_valid = (count_reg != 2'd0);
    assign out_data  = mem_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_comb
    begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= in_data;
        end
    end

endmodule

[hw/rtl/mssd_back.sv]
// Back end: owns the display buffer and scan index, applies ops, registers scan output.
module mssd_back #(
    parameter int DIGITS = mssd_pkg::DIGITS_DEFAULT
) (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    op_valid,
    output logic                                    op_ready,
    input  mssd_pkg::kind_t                         op_kind,
    input  logic [DIGITS-1:0]                       op_mask,
    input  logic [DIGITS-1:0][mssd_pkg::CODE_W-1:0] op_codes,
    mssd_result_if.source                           result
);
    import mssd_pkg::*;

    localparam int PW = (DIGITS > 1) ? $clog2(DIGITS) : 1;

    logic [CODE_W-1:0]   disp_reg  [DIGITS];
    logic [CODE_W-1:0]   disp_next [DIGITS];
    logic [PW-1:0]       scan_reg;
    logic [PW-1:0]       scan_next;
    logic                out_valid_reg;
    logic                out_valid_next;
    logic [CODE_W-1:0]   seg_reg;
    logic [CODE_W-1:0]   seg_next;
    logic [ENABLE_W-1:0] en_reg;
    logic [ENABLE_W-1:0] en_next;
    logic                pop;
    logic                tick;

    assign tick     = (op_kind == KIND_TICK);
    // a tick needs the output slot free or draining this cycle
    assign op_ready = !tick || !out_valid_reg || result.ready;
    assign pop      = op_valid && op_ready;

    always_comb
    begin
        for (int p = 0; p < DIGITS; p++)
        begin
            disp_next[p] = disp_reg[p];
            if (pop && op_mask[p])
            begin
                if (op_kind == KIND_TOGGLE)
                begin
                    disp_next[p] = disp_reg[p] ^ DP_MASK;
                end
                else
                begin
                    disp_next[p] = (disp_reg[p] & DP_MASK) | op_codes[p];
                end
            end
        end

        scan_next      = scan_reg;
        seg_next       = seg_reg;
        en_next        = en_reg;
        out_valid_next = result.ready ? 1'b0 : out_valid_reg;
        if (pop && tick)
        begin
            out_valid_next = 1'b1;
            seg_next = disp_reg[scan_reg];
            for (int j = 0; j < ENABLE_W; j++)
            begin
                en_next[j] = (int'(scan_reg) == j);
            end
            scan_next = (scan_reg == PW'(DIGITS - 1)) ? '0 : scan_reg + PW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int p = 0; p < DIGITS; p++)
            begin
                disp_reg[p] <= '0;
            end
            scan_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            for (int p = 0; p < DIGITS; p++)
            begin
                disp_reg[p] <= disp_next[p];
            end
            scan_reg      <= scan_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        seg_reg <= seg_next;
        en_reg  <= en_next;
    end

    assign result.valid        = out_valid_reg;
    assign result.segments     = seg_reg;
    assign result.digit_enable = en_reg;

endmodule

[hw/rtl/multiplexed_seven_segment_driver.sv]
// Top level of the multiplexed seven-segment display driver.
//
// item channel (valid/ready): kind selects a scan tick, a number write, a raw code
// write or a decimal point toggle. result channel: one transfer per scan tick with
// the scanned position's segment byte and a one-hot digit enable.
// cfg_wr_en/cfg_wr_data write number_mode; change it only while the block is idle.
//
// Throughput: one item per cycle unless a result stall backs up the stages. An item
// moves through DIGITS digit extraction stages (one divide-by-ten per stage), a
// two-entry queue and the back end's output register before a tick's result shows up.
// Buffer writes become visible to ticks in item order.
//
// Reset clears the buffer, the scan index and all valid flags; number_mode
// resets to significant-digits-only. When the result receiver stalls, the held
// result stays, ticks back up into the queue and digit stages, and item.ready
// drops once every stage is full; writes ahead of a stalled tick still complete.
module multiplexed_seven_segment_driver #(
    parameter int DIGITS = mssd_pkg::DIGITS_DEFAULT
) (
    input  logic          clk,
    input  logic          rst_n,
    mssd_item_if.sink     item,
    mssd_result_if.source result,
    input  logic          cfg_wr_en,
    input  logic [1:0]    cfg_wr_data
);
    import mssd_pkg::*;

    localparam int OP_W = 2 + DIGITS + DIGITS * CODE_W;

    logic [1:0]                   mode_reg;
    logic                         f_valid;
    logic                         f_ready;
    kind_t                        f_kind;
    logic [DIGITS-1:0]            f_mask;
    logic [DIGITS-1:0][CODE_W-1:0] f_codes;
    logic [OP_W-1:0]              q_in;
    logic [OP_W-1:0]              q_out;
    logic                         op_valid;
    logic                         op_ready;
    kind_t                        op_kind;
    logic [DIGITS-1:0]            op_mask;
    logic [DIGITS-1:0][CODE_W-1:0] op_codes;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= MODE_SIGNIFICANT;
        end
        else if (cfg_wr_en)
        begin
            mode_reg <= cfg_wr_data;
        end
    end

    mssd_front #(.DIGITS(DIGITS)) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .item        (item),
        .number_mode (mode_reg),
        .op_valid    (f_valid),
        .op_ready    (f_ready),
        .op_kind     (f_kind),
        .op_mask     (f_mask),
        .op_codes    (f_codes)
    );

    assign q_in = {f_kind, f_mask, f_codes};

    mssd_fifo #(.WIDTH(OP_W)) u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (f_valid),
        .in_ready  (f_ready),
        .in_data   (q_in),
        .out_valid (op_valid),
        .out_ready (op_ready),
        .out_data  (q_out)
    );

    assign op_kind  = kind_t'(q_out[OP_W-1 -: 2]);
    assign op_mask  = q_out[DIGITS*CODE_W +: DIGITS];
    assign op_codes = q_out[DIGITS*CODE_W-1:0];

    mssd_back #(.DIGITS(DIGITS)) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .op_valid (op_valid),
        .op_ready (op_ready),
        .op_kind  (op_kind),
        .op_mask  (op_mask),
        .op_codes (op_codes),
        .result   (result)
    );

    // a tick leaves the queue only when the output register can take it
    a_tick_slot: assert property (@(posedge clk) disable iff (!rst_n)
        (op_valid && op_ready && op_kind == KIND_TICK) |-> (!result.valid || result.ready))
        else $error("tick transfer with output register occupied");

    a_tick_no_write: assert property (@(posedge clk) disable iff (!rst_n)
        (op_valid && op_kind == KIND_TICK) |-> (op_mask == '0))
        else $error("tick op carries a buffer write");

    a_single_pos: assert property (@(posedge clk) disable iff (!rst_n)
        (op_valid && (op_kind == KIND_RAW || op_kind == KIND_TOGGLE)) |-> $onehot(op_mask))
        else $error("raw or toggle op does not hit exactly one position");

    a_enable_hot: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid |-> $onehot0(result.digit_enable))
        else $error("digit enable has more than one bit set");

endmodule
